// ===== hw/rtl/triangle_local_basis_unit_defines.svh =====
// Assertion macros for the top-level RTL file of the local basis unit.
`ifndef TRIANGLE_LOCAL_BASIS_UNIT_DEFINES_SVH
`define TRIANGLE_LOCAL_BASIS_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TLB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle_local_basis_unit: assertion failed");
`define TLB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle_local_basis_unit: assertion failed");
`else
`define TLB_ASSERT_IMP(lbl, ante, cons)
`define TLB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/tlb_pkg.sv =====
package tlb_pkg;

    localparam int COORD_W  = 32;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int MAG_W    = 30;
    localparam int RED_W    = MAG_W + 1;
    localparam int PROD_W   = 2 * RED_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int RAD_W    = 2 * RED_W;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int Q30      = 30;
    localparam int NUM_W    = MAG_W + Q30 + 1;
    localparam int QUO_W    = 31;
    localparam int AXIS_W   = 32;
    localparam int AXPROD_W = 2 * AXIS_W;
    localparam int UNIT_LAT = 4 + ROOT_W + QUO_W;
    localparam int Y_ALIGN  = 3;

    typedef struct packed {
        logic valid;
        logic last;
        logic degen;
    } ctrl_t;

endpackage

// ===== hw/rtl/tlb_delay.sv =====
module tlb_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                line_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];
endmodule

// ===== hw/rtl/tlb_reduce.sv =====
module tlb_reduce #(
    parameter int IN_W = 33
) (
    input  logic signed [IN_W-1:0]          vec [3],
    output logic signed [tlb_pkg::RED_W-1:0] red [3]
);
    import tlb_pkg::*;

    localparam int SH_W = $clog2(IN_W);

    logic [IN_W-1:0] mag [3];
    logic [IN_W-1:0] sh  [3];
    logic [IN_W-1:0] mx;
    logic [SH_W-1:0] msb;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = vec[i][IN_W-1] ? IN_W'(~$unsigned(vec[i]) + 1'b1) : $unsigned(vec[i]);
        end
        mx = mag[0];
        if (mag[1] > mx)
        begin
            mx = mag[1];
        end
        if (mag[2] > mx)
        begin
            mx = mag[2];
        end
        msb = '0;
        for (int k = 0; k < IN_W; k++)
        begin
            if (mx[k])
            begin
                msb = SH_W'(k);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (msb > SH_W'(MAG_W - 1))
            begin
                sh[i] = mag[i] >> (msb - SH_W'(MAG_W - 1));
            end
            else
            begin
                sh[i] = mag[i] << (SH_W'(MAG_W - 1) - msb);
            end
            red[i] = vec[i][IN_W-1] ? -$signed(RED_W'(sh[i][MAG_W-1:0]))
                                    : $signed(RED_W'(sh[i][MAG_W-1:0]));
        end
    end
endmodule

// ===== hw/rtl/tlb_sqrt.sv =====
module tlb_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [tlb_pkg::RAD_W-1:0]    radicand,
    output logic [tlb_pkg::ROOT_W-1:0]   root
);
    import tlb_pkg::*;

    localparam int STAGES = ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [STAGES-1];
    logic [ROOT_W-1:0] root_reg [STAGES];
    logic [RAD_W-1:0]  rad_reg  [STAGES-1];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              take;
        logic [REM_W-1:0]  rem_nx;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign take   = rem_sh >= trial;
        assign rem_nx = take ? rem_sh - trial : rem_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= {root_in[ROOT_W-2:0], take};
            end
        end

        if (s < STAGES - 1)
        begin : g_rad
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_nx;
                    rad_reg[s] <= {rad_in[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[STAGES-1];
endmodule

// ===== hw/rtl/tlb_div.sv =====
module tlb_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [tlb_pkg::NUM_W-1:0]   num,
    input  logic [tlb_pkg::ROOT_W-1:0]  den,
    output logic [tlb_pkg::QUO_W-1:0]   quo
);
    import tlb_pkg::*;

    localparam int STAGES = QUO_W;
    localparam int REM_W  = ROOT_W + 1;

    logic [REM_W-1:0]  rem_reg [STAGES-1];
    logic [QUO_W-1:0]  low_reg [STAGES-1];
    logic [ROOT_W-1:0] den_reg [STAGES-1];
    logic [QUO_W-1:0]  quo_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [QUO_W-1:0]  low_in;
        logic [ROOT_W-1:0] den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [REM_W-1:0]  rem_sh;
        logic              take;

        if (s == 0)
        begin : g_first
            assign rem_in = REM_W'(num[NUM_W-1:QUO_W]);
            assign low_in = num[QUO_W-1:0];
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign low_in = low_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign rem_sh = {rem_in[REM_W-2:0], low_in[QUO_W-1]};
        assign take   = rem_sh >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= {quo_in[QUO_W-2:0], take};
            end
        end

        if (s < STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? rem_sh - {1'b0, den_in} : rem_sh;
                    low_reg[s] <= {low_in[QUO_W-2:0], 1'b0};
                    den_reg[s] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[STAGES-1];
endmodule

// ===== hw/rtl/tlb_unit.sv =====
module tlb_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic signed [tlb_pkg::RED_W-1:0]   vec_in   [3],
    output logic signed [tlb_pkg::AXIS_W-1:0]  unit_out [3]
);
    import tlb_pkg::*;

    localparam int SIDE_W = 3 * (MAG_W + 1);

    logic [MAG_W-1:0]  m1_reg [3];
    logic              neg1_reg [3];
    logic [SQ_W-1:0]   sq1_reg [3];
    logic [MAG_W-1:0]  m2_reg [3];
    logic              neg2_reg [3];
    logic [RAD_W-1:0]  sum2_reg;
    logic [ROOT_W-1:0] root;
    logic [SIDE_W-1:0] side_in;
    logic [SIDE_W-1:0] side_out;
    logic [MAG_W-1:0]  m_d [3];
    logic              neg_d [3];
    logic [NUM_W-1:0]  num3_reg [3];
    logic [ROOT_W-1:0] den3_reg;
    logic [2:0]        neg3_reg;
    logic [2:0]        neg4;
    logic [QUO_W-1:0]  quo [3];
    logic signed [AXIS_W-1:0] out_reg [3];
    logic signed [RED_W-1:0]  abs_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_next[i] = vec_in[i][RED_W-1] ? -vec_in[i] : vec_in[i];
            side_in[i*(MAG_W+1) +: MAG_W+1] = {neg2_reg[i], m2_reg[i]};
            {neg_d[i], m_d[i]} = side_out[i*(MAG_W+1) +: MAG_W+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_reg[i]   <= abs_next[i][MAG_W-1:0];
                neg1_reg[i] <= vec_in[i][RED_W-1];
                sq1_reg[i]  <= abs_next[i][MAG_W-1:0] * abs_next[i][MAG_W-1:0];
                m2_reg[i]   <= m1_reg[i];
                neg2_reg[i] <= neg1_reg[i];
                num3_reg[i] <= (NUM_W'(m_d[i]) << Q30) + NUM_W'(root >> 1);
                neg3_reg[i] <= neg_d[i];
                out_reg[i]  <= neg4[i] ? -$signed(AXIS_W'(quo[i])) : $signed(AXIS_W'(quo[i]));
            end
            sum2_reg <= RAD_W'(sq1_reg[0]) + RAD_W'(sq1_reg[1]) + RAD_W'(sq1_reg[2]);
            den3_reg <= root;
        end
    end

    tlb_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum2_reg),
        .root     (root)
    );

    tlb_delay #(.W(SIDE_W), .DEPTH(ROOT_W)) u_side_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (side_in),
        .dout  (side_out)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        tlb_div u_div (
            .clk (clk),
            .en  (en),
            .num (num3_reg[i]),
            .den (den3_reg),
            .quo (quo[i])
        );
    end

    tlb_delay #(.W(3), .DEPTH(QUO_W)) u_sign_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (neg3_reg),
        .dout  (neg4)
    );

    assign unit_out = out_reg;
endmodule

// ===== hw/rtl/triangle_local_basis_unit.sv =====
// Local coordinate frame of one triangle element.
// The input channel (in_valid, in_ready) carries the vertices p, r, q in signed
// fixed point and a last_element mark; the output channel (out_valid, out_ready)
// carries the x, y and z axes in signed Q1.30, a degenerate flag and last_out.
// Every transaction gives exactly one result, in order.
// Throughput is one transaction per cycle while the receiver does not stall,
// held up by the two fully pipelined normalizers, each a 31 stage square root
// followed by three 31 stage restoring dividers, one result bit per stage.
// When the edge p to q, or the cross product of the edges, is zero the result
// has degenerate set and all nine axis fields zero.
// The whole pipeline advances together: while out_valid is high and out_ready
// is low, every stage holds, in_ready is low, and nothing is lost or repeated.
// Reset clears every valid bit; the block accepts a transaction in the first
// cycle after reset is released.
`include "triangle_local_basis_unit_defines.svh"

module triangle_local_basis_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tlb_pkg::COORD_W-1:0]  p_x,
    input  logic signed [tlb_pkg::COORD_W-1:0]  p_y,
    input  logic signed [tlb_pkg::COORD_W-1:0]  p_z,
    input  logic signed [tlb_pkg::COORD_W-1:0]  r_x,
    input  logic signed [tlb_pkg::COORD_W-1:0]  r_y,
    input  logic signed [tlb_pkg::COORD_W-1:0]  r_z,
    input  logic signed [tlb_pkg::COORD_W-1:0]  q_x,
    input  logic signed [tlb_pkg::COORD_W-1:0]  q_y,
    input  logic signed [tlb_pkg::COORD_W-1:0]  q_z,
    input  logic                                last_element,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tlb_pkg::AXIS_W-1:0]   xaxis_x,
    output logic signed [tlb_pkg::AXIS_W-1:0]   xaxis_y,
    output logic signed [tlb_pkg::AXIS_W-1:0]   xaxis_z,
    output logic signed [tlb_pkg::AXIS_W-1:0]   yaxis_x,
    output logic signed [tlb_pkg::AXIS_W-1:0]   yaxis_y,
    output logic signed [tlb_pkg::AXIS_W-1:0]   yaxis_z,
    output logic signed [tlb_pkg::AXIS_W-1:0]   zaxis_x,
    output logic signed [tlb_pkg::AXIS_W-1:0]   zaxis_y,
    output logic signed [tlb_pkg::AXIS_W-1:0]   zaxis_z,
    output logic                                degenerate,
    output logic                                last_out
);
    import tlb_pkg::*;

    localparam int YPK_W = 3 * AXIS_W;
    localparam int RND_W = AXPROD_W - Q30 + 1;

    logic adv;

    ctrl_t ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg, ctrl5_reg, ctrl6_reg;
    ctrl_t ctrl1_next, ctrl2_next, ctrl5_next, ctrl_d;
    logic [$bits(ctrl_t)-1:0] ctrl_d_raw;
    logic out_valid_reg;

    logic signed [EDGE_W-1:0]   a_next [3], b_next [3];
    logic signed [EDGE_W-1:0]   a_reg [3], b_reg [3];
    logic signed [RED_W-1:0]    ar_next [3], br_next [3], cr_next [3];
    logic signed [RED_W-1:0]    ar_reg [3], br_reg [3], cr_reg [3];
    logic signed [PROD_W-1:0]   prod_reg [6];
    logic signed [CROSS_W-1:0]  c_reg [3];
    logic signed [AXIS_W-1:0]   y_unit [3], z_unit [3], y_al [3];
    logic [YPK_W-1:0]           y_pk, y_al_pk;
    logic signed [AXPROD_W-1:0] axprod_reg [6];
    logic signed [AXIS_W-1:0]   y6_reg [3], z6_reg [3];
    logic signed [AXIS_W-1:0]   x_next [3];
    logic signed [AXIS_W-1:0]   x_out_reg [3], y_out_reg [3], z_out_reg [3];
    logic                       degen_reg, last_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        a_next[0] = EDGE_W'(q_x) - EDGE_W'(p_x);
        a_next[1] = EDGE_W'(q_y) - EDGE_W'(p_y);
        a_next[2] = EDGE_W'(q_z) - EDGE_W'(p_z);
        b_next[0] = EDGE_W'(r_x) - EDGE_W'(p_x);
        b_next[1] = EDGE_W'(r_y) - EDGE_W'(p_y);
        b_next[2] = EDGE_W'(r_z) - EDGE_W'(p_z);
        ctrl1_next = '{valid: in_valid, last: last_element, degen: 1'b0};
        ctrl2_next = ctrl1_reg;
        ctrl2_next.degen = (a_reg[0] == '0) && (a_reg[1] == '0) && (a_reg[2] == '0);
        ctrl5_next = ctrl4_reg;
        ctrl5_next.degen = ctrl4_reg.degen ||
                           ((c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0));
    end

    tlb_reduce #(.IN_W(EDGE_W)) u_red_a (.vec(a_reg), .red(ar_next));
    tlb_reduce #(.IN_W(EDGE_W)) u_red_b (.vec(b_reg), .red(br_next));
    tlb_reduce #(.IN_W(CROSS_W)) u_red_c (.vec(c_reg), .red(cr_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg     <= '0;
            ctrl2_reg     <= '0;
            ctrl3_reg     <= '0;
            ctrl4_reg     <= '0;
            ctrl5_reg     <= '0;
            ctrl6_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctrl1_reg     <= ctrl1_next;
            ctrl2_reg     <= ctrl2_next;
            ctrl3_reg     <= ctrl2_reg;
            ctrl4_reg     <= ctrl3_reg;
            ctrl5_reg     <= ctrl5_next;
            ctrl6_reg     <= ctrl_d;
            out_valid_reg <= ctrl6_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i]  <= a_next[i];
                b_reg[i]  <= b_next[i];
                ar_reg[i] <= ar_next[i];
                br_reg[i] <= br_next[i];
                cr_reg[i] <= cr_next[i];
                y6_reg[i] <= y_al[i];
                z6_reg[i] <= z_unit[i];
                x_out_reg[i] <= ctrl6_reg.degen ? '0 : x_next[i];
                y_out_reg[i] <= ctrl6_reg.degen ? '0 : y6_reg[i];
                z_out_reg[i] <= ctrl6_reg.degen ? '0 : z6_reg[i];
            end
            prod_reg[0] <= br_reg[1] * ar_reg[2];
            prod_reg[1] <= br_reg[2] * ar_reg[1];
            prod_reg[2] <= br_reg[2] * ar_reg[0];
            prod_reg[3] <= br_reg[0] * ar_reg[2];
            prod_reg[4] <= br_reg[0] * ar_reg[1];
            prod_reg[5] <= br_reg[1] * ar_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= CROSS_W'(prod_reg[2*i]) - CROSS_W'(prod_reg[2*i+1]);
            end
            axprod_reg[0] <= y_al[1] * z_unit[2];
            axprod_reg[1] <= y_al[2] * z_unit[1];
            axprod_reg[2] <= y_al[2] * z_unit[0];
            axprod_reg[3] <= y_al[0] * z_unit[2];
            axprod_reg[4] <= y_al[0] * z_unit[1];
            axprod_reg[5] <= y_al[1] * z_unit[0];
            degen_reg <= ctrl6_reg.degen;
            last_reg  <= ctrl6_reg.last;
        end
    end

    tlb_unit u_unit_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vec_in   (ar_reg),
        .unit_out (y_unit)
    );

    tlb_unit u_unit_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vec_in   (cr_reg),
        .unit_out (z_unit)
    );

    assign y_pk = {y_unit[2], y_unit[1], y_unit[0]};
    assign {y_al[2], y_al[1], y_al[0]} = y_al_pk;

    tlb_delay #(.W(YPK_W), .DEPTH(Y_ALIGN)) u_y_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   (y_pk),
        .dout  (y_al_pk)
    );

    tlb_delay #(.W($bits(ctrl_t)), .DEPTH(UNIT_LAT)) u_ctrl_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   (ctrl5_reg),
        .dout  (ctrl_d_raw)
    );

    assign ctrl_d = ctrl_t'(ctrl_d_raw);

    always_comb
    begin
        logic signed [AXPROD_W-1:0] t;
        logic [AXPROD_W-1:0]        tmag;
        logic [RND_W-1:0]           rm;
        for (int i = 0; i < 3; i++)
        begin
            t    = axprod_reg[2*i] - axprod_reg[2*i+1];
            tmag = t[AXPROD_W-1] ? $unsigned(-t) : $unsigned(t);
            rm   = RND_W'((tmag + (AXPROD_W'(1) << (Q30 - 1))) >> Q30);
            if (rm > (RND_W'(1) << Q30))
            begin
                rm = RND_W'(1) << Q30;
            end
            x_next[i] = t[AXPROD_W-1] ? -$signed(AXIS_W'(rm)) : $signed(AXIS_W'(rm));
        end
    end

    assign out_valid  = out_valid_reg;
    assign xaxis_x    = x_out_reg[0];
    assign xaxis_y    = x_out_reg[1];
    assign xaxis_z    = x_out_reg[2];
    assign yaxis_x    = y_out_reg[0];
    assign yaxis_y    = y_out_reg[1];
    assign yaxis_z    = y_out_reg[2];
    assign zaxis_x    = z_out_reg[0];
    assign zaxis_y    = z_out_reg[1];
    assign zaxis_z    = z_out_reg[2];
    assign degenerate = degen_reg;
    assign last_out   = last_reg;

    `TLB_ASSERT_IMP(a_degen_zero, out_valid && degenerate,
        xaxis_x == 0 && yaxis_y == 0 && zaxis_z == 0 && zaxis_x == 0)
    `TLB_ASSERT_IMP(a_y_nonzero, out_valid && !degenerate,
        yaxis_x != 0 || yaxis_y != 0 || yaxis_z != 0)
    `TLB_ASSERT_IMP(a_z_bound, out_valid && !degenerate,
        zaxis_x <= 32'sd1073741824 && zaxis_x >= -32'sd1073741824)
    `TLB_ASSERT_NXT(a_accept_enters, in_valid && in_ready, ctrl1_reg.valid)
endmodule
